/* rtl/stop_and_wait_ack_retry_controller_macros.svh */
// assertion macros for the stop-and-wait retry controller
// used by the modules that carry concurrent assertions; no dependencies
`ifndef STOP_AND_WAIT_ACK_RETRY_CONTROLLER_MACROS_SVH
`define STOP_AND_WAIT_ACK_RETRY_CONTROLLER_MACROS_SVH

// same-cycle implication, disabled during reset
`define SWARC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swarc assertion failed");

// next-cycle implication, disabled during reset
`define SWARC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swarc assertion failed");

`endif

/* rtl/swarc_pkg.sv */
// shared types and codes for the stop-and-wait retry controller
// no dependencies; imported by the interfaces, the config block, the engine and the top level
package swarc_pkg;

  localparam int unsigned CFG_AW = 4;

  localparam logic [1:0] REG_MAX_ATTEMPTS = 2'd0;
  localparam logic [1:0] REG_ACK_TIMEOUT  = 2'd1;
  localparam logic [1:0] REG_TX_GUARD     = 2'd2;
  localparam logic [1:0] REG_NEXT_DELAY   = 2'd3;

  localparam logic [3:0]  RST_MAX_ATTEMPTS = 4'd3;
  localparam logic [15:0] RST_ACK_TIMEOUT  = 16'd5000;
  localparam logic [15:0] RST_TX_GUARD     = 16'd6000;
  localparam logic [19:0] RST_NEXT_DELAY   = 20'd10000;
  localparam logic [31:0] RST_SEQUENCE     = 32'd1;

  localparam logic [2:0] PH_DISABLED  = 3'd0;
  localparam logic [2:0] PH_START_TX  = 3'd1;
  localparam logic [2:0] PH_WAIT_TX   = 3'd2;
  localparam logic [2:0] PH_WAIT_ACK  = 3'd3;
  localparam logic [2:0] PH_WAIT_NEXT = 3'd4;

  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_TX        = 3'd1;
  localparam logic [2:0] EV_RETRY     = 3'd2;
  localparam logic [2:0] EV_SUCCESS   = 3'd3;
  localparam logic [2:0] EV_FAIL      = 3'd4;
  localparam logic [2:0] EV_IGNORED   = 3'd5;
  localparam logic [2:0] EV_INIT_FAIL = 3'd6;

  localparam logic [1:0] CMD_NONE     = 2'd0;
  localparam logic [1:0] CMD_START_TX = 2'd1;
  localparam logic [1:0] CMD_START_RX = 2'd2;

  localparam logic MODE_INIT = 1'b0;

  typedef struct packed {
    logic [3:0]  max_attempts;
    logic [15:0] ack_timeout_ms;
    logic [15:0] tx_guard_ms;
    logic [19:0] next_packet_delay_ms;
  } cfg_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] now_ms;
    logic        radio_cmd_ok;
    logic        irq_read_ok;
    logic        irq_pending;
    logic        irq_tx_done;
    logic        irq_rx_done;
    logic        irq_bad_packet;
    logic        irq_timeout;
    logic        format_ok;
    logic        read_ok;
    logic        ack_matches;
  } item_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] rx_window_ms;
    logic [2:0]  event_code;
    logic [31:0] current_sequence;
    logic [3:0]  current_attempt;
    logic [2:0]  fsm_state;
  } res_t;

endpackage

/* rtl/swarc_if.sv */
// valid/ready channel interfaces for input items and result items
// depends on swarc_pkg for the payload types
interface swarc_in_if import swarc_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface swarc_out_if import swarc_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/swarc_cfg.sv */
// apb-style configuration registers of the retry controller
// depends on swarc_pkg
module swarc_cfg import swarc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_attempts         <= RST_MAX_ATTEMPTS;
      cfg_r.ack_timeout_ms       <= RST_ACK_TIMEOUT;
      cfg_r.tx_guard_ms          <= RST_TX_GUARD;
      cfg_r.next_packet_delay_ms <= RST_NEXT_DELAY;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MAX_ATTEMPTS: cfg_r.max_attempts         <= pwdata[3:0];
        REG_ACK_TIMEOUT:  cfg_r.ack_timeout_ms       <= pwdata[15:0];
        REG_TX_GUARD:     cfg_r.tx_guard_ms          <= pwdata[15:0];
        REG_NEXT_DELAY:   cfg_r.next_packet_delay_ms <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAX_ATTEMPTS: prdata = {28'd0, cfg_r.max_attempts};
      REG_ACK_TIMEOUT:  prdata = {16'd0, cfg_r.ack_timeout_ms};
      REG_TX_GUARD:     prdata = {16'd0, cfg_r.tx_guard_ms};
      REG_NEXT_DELAY:   prdata = {12'd0, cfg_r.next_packet_delay_ms};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

/* rtl/swarc_engine.sv */
// transaction state and per-beat next-state logic of the retry controller
// depends on swarc_pkg and the assertion macro header
`include "stop_and_wait_ack_retry_controller_macros.svh"

module swarc_engine import swarc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  fire,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  logic [2:0]  phase_r, phase_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [31:0] dl_r, dl_nxt;
  logic [3:0]  att_r, att_nxt;

  logic [31:0] since_dl;
  logic [31:0] left;
  logic        reached;
  logic [15:0] win_left;
  logic [31:0] seq_inc;

  logic        do_fail;
  logic        do_end;
  logic        end_ok;
  logic        reopen;
  logic [1:0]  cmd;
  logic [15:0] win;
  logic [2:0]  ev;

  assign since_dl = item.now_ms - dl_r;
  assign reached  = !since_dl[31];
  assign left     = dl_r - item.now_ms;
  assign win_left = (|left[31:16]) ? 16'hFFFF : left[15:0];
  assign seq_inc  = seq_r + 32'd1;

  always_comb begin
    phase_nxt = phase_r;
    seq_nxt   = seq_r;
    dl_nxt    = dl_r;
    att_nxt   = att_r;
    ev        = EV_NONE;
    cmd       = CMD_NONE;
    win       = 16'd0;
    do_fail   = 1'b0;
    do_end    = 1'b0;
    end_ok    = 1'b0;
    reopen    = 1'b0;

    if (item.mode == MODE_INIT) begin
      phase_nxt = PH_DISABLED;
      if (!item.radio_cmd_ok) begin
        ev = EV_INIT_FAIL;
      end else begin
        seq_nxt   = RST_SEQUENCE;
        att_nxt   = 4'd1;
        phase_nxt = PH_START_TX;
      end
    end else begin
      case (phase_r)
        PH_START_TX: begin
          if (!item.format_ok) begin
            do_end = 1'b1;
          end else begin
            cmd = CMD_START_TX;
            if (!item.radio_cmd_ok) begin
              do_fail = 1'b1;
            end else begin
              ev        = EV_TX;
              dl_nxt    = item.now_ms + {16'd0, cfg.tx_guard_ms};
              phase_nxt = PH_WAIT_TX;
            end
          end
        end
        PH_WAIT_NEXT: begin
          if (reached) begin
            att_nxt   = 4'd1;
            phase_nxt = PH_START_TX;
          end
        end
        PH_WAIT_TX: begin
          if (!item.irq_read_ok) begin
            do_fail = 1'b1;
          end else if (!item.irq_pending) begin
            do_fail = reached;
          end else if (item.irq_tx_done) begin
            dl_nxt = item.now_ms + {16'd0, cfg.ack_timeout_ms};
            cmd    = CMD_START_RX;
            win    = cfg.ack_timeout_ms;
            if (!item.radio_cmd_ok) begin
              do_fail = 1'b1;
            end else begin
              phase_nxt = PH_WAIT_ACK;
            end
          end else if (item.irq_timeout) begin
            do_fail = 1'b1;
          end
        end
        PH_WAIT_ACK: begin
          if (!item.irq_read_ok) begin
            do_fail = 1'b1;
          end else if (!item.irq_pending) begin
            do_fail = reached;
          end else if (item.irq_rx_done) begin
            if (!item.read_ok) begin
              reopen = 1'b1;
            end else if (item.ack_matches) begin
              do_end = 1'b1;
              end_ok = 1'b1;
            end else begin
              ev     = EV_IGNORED;
              reopen = 1'b1;
            end
          end else if (item.irq_bad_packet) begin
            ev     = EV_IGNORED;
            reopen = 1'b1;
          end else if (item.irq_timeout) begin
            do_fail = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // restart the receive window with the time still left, or fail if the deadline has passed or the radio refuses
    if (reopen) begin
      if (reached) begin
        do_fail = 1'b1;
      end else begin
        cmd = CMD_START_RX;
        win = win_left;
        if (!item.radio_cmd_ok) begin
          do_fail = 1'b1;
        end
      end
    end

    if (do_fail) begin
      if (att_r < cfg.max_attempts) begin
        att_nxt   = att_r + 4'd1;
        phase_nxt = PH_START_TX;
        ev        = EV_RETRY;
      end else begin
        do_end = 1'b1;
      end
    end

    if (do_end) begin
      seq_nxt   = (seq_inc == 32'd0) ? 32'd1 : seq_inc;
      dl_nxt    = item.now_ms + {12'd0, cfg.next_packet_delay_ms};
      phase_nxt = PH_WAIT_NEXT;
      ev        = end_ok ? EV_SUCCESS : EV_FAIL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DISABLED;
      seq_r   <= RST_SEQUENCE;
      dl_r    <= 32'd0;
      att_r   <= 4'd0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      seq_r   <= seq_nxt;
      dl_r    <= dl_nxt;
      att_r   <= att_nxt;
    end
  end

  assign res.command          = cmd;
  assign res.rx_window_ms     = win;
  assign res.event_code       = ev;
  assign res.current_sequence = seq_nxt;
  assign res.current_attempt  = att_nxt;
  assign res.fsm_state        = phase_nxt;

  `SWARC_ASSERT_NOW(a_seq_nonzero, clk, rst_n, 1'b1, seq_r != 32'd0)
  `SWARC_ASSERT_NEXT(a_idle_holds, clk, rst_n, !fire,
                     $stable(phase_r) && $stable(seq_r) && $stable(att_r))
  `SWARC_ASSERT_NOW(a_tx_enter_cmd, clk, rst_n,
                    fire && phase_nxt == PH_WAIT_TX && phase_r != PH_WAIT_TX,
                    cmd == CMD_START_TX && ev == EV_TX)
  `SWARC_ASSERT_NEXT(a_end_waits, clk, rst_n,
                     fire && (ev == EV_SUCCESS || ev == EV_FAIL),
                     phase_r == PH_WAIT_NEXT && seq_r != $past(seq_r))

endmodule

/* rtl/stop_and_wait_ack_retry_controller.sv */
// top level of the stop-and-wait transmit controller with ack timeout and retry
// depends on swarc_pkg, swarc_if, swarc_cfg and swarc_engine
//
// usage:
//   in_ch carries one beat per init request or poll: mode, the millisecond tick
//   and the radio outcomes seen for that step. out_ch returns exactly one beat
//   per input beat: the radio command to issue, the receive window, an event
//   code and the sequence, attempt and state after the step.
//   configuration goes through the apb-style port (max_attempts at 0x0,
//   ack_timeout_ms at 0x4, tx_guard_ms at 0x8, next_packet_delay_ms at 0xc);
//   write it only while no beat is in flight.
//   a beat accepted into the input register is stepped through the state
//   machine as it moves into the output register, from which it is valid on
//   out_ch; a stall on out_ch can hold it in the input register.
//   throughput: one beat per cycle unless out_ch stalls; one update per beat.
//   reset: state disabled, sequence 1, attempt 0, deadline 0, registers at their
//   defaults, both pipeline stages empty.
//   when out_ch stalls the result stays in the output register, one more beat
//   waits in the input register, and in_ch.ready drops until out_ch drains.
module stop_and_wait_ack_retry_controller import swarc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  swarc_in_if.sink          in_ch,
  swarc_out_if.source       out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t  cfg;
  logic  in_valid_r;
  item_t in_item_r;
  logic  out_valid_r;
  res_t  out_res_r;
  res_t  step_res;
  logic  advance;

  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  swarc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  swarc_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_item_r <= in_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_res_r;

endmodule
